// File: rtl/supply_switchover_sequencer_top_macros.svh
// ---------------------------------------------------------------------------
// Supply switchover sequencer assertion macros
// Immediate-implication and next-cycle-implication checks, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SUPPLY_SWITCHOVER_SEQUENCER_TOP_MACROS_SVH
`define SUPPLY_SWITCHOVER_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define SSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define SSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SSS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/sss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Supply switchover sequencer package
// Configuration table, action codes and controller/datapath link types.
// ---------------------------------------------------------------------------
package sss_pkg;

   localparam int TableEntriesDefault   = 16;
   localparam int ConsumerRelaysDefault = 7;
   localparam int StoredEntries         = 16;

   localparam logic [15:0] SETTLE_RESET = 16'd500;
   localparam logic [2:0]  SUPPLY_RELAY = 3'd7;

   // Target kinds
   localparam logic [1:0] KIND_RELAY     = 2'd0;
   localparam logic [1:0] KIND_ALT       = 2'd1;
   localparam logic [1:0] KIND_C7_DIRECT = 2'd2;
   localparam logic [1:0] KIND_C7_ALT    = 2'd3;

   // Entry bit positions
   localparam int BitSupplyOff = 7;
   localparam int BitAlt       = 8;
   localparam int BitC7Direct  = 9;
   localparam int BitC7Alt     = 10;

   typedef logic [10:0] sss_entry_type;

   // Fixed switch configuration table
   localparam sss_entry_type CONF_TABLE [StoredEntries] = '{
      11'h200, 11'h304, 11'h344, 11'h364, 11'h374, 11'h37C, 11'h37D, 11'h57F,
      11'h5FB, 11'h5BB, 11'h59B, 11'h58B, 11'h583, 11'h582, 11'h580, 11'h080
   };

   // Action codes from controller to datapath
   typedef enum logic [3:0] {
      OP_C7D_OFF,
      OP_C7A_OFF,
      OP_ALT_OFF,
      OP_SUP_ON,
      OP_CONS_ON,
      OP_SUP_OFF,
      OP_CONS_OFF,
      OP_ALT_ON,
      OP_CONS_SET,
      OP_C7_FIRST,
      OP_C7_SECOND
   } sss_op_type;

   typedef struct packed {
      logic       emit;
      sss_op_type op;
      logic [2:0] idx;
   } sss_cmd_type;

   typedef struct packed {
      logic req_ok;
      logic on12;
      logic onalt;
      logic conf_alt;
      logic conf_sup_off;
      logic out_free;
   } sss_sts_type;

endpackage

// File: rtl/sss_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Supply switchover sequencer controller
// Walks the action phases of one transition, one action per cycle while the result register can take it.
// ---------------------------------------------------------------------------
module sss_ctrl import sss_pkg::*; #(
   parameter int CONSUMER_RELAYS = ConsumerRelaysDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   output logic        req_tready,
   input  sss_sts_type sts,
   output sss_cmd_type cmd
);

   localparam logic [2:0] CONS_LAST = 3'(CONSUMER_RELAYS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_C7D_OFF,
      S_C7A_OFF,
      S_ALT_OFF,
      S_SUP_ON,
      S_HAND_ON,
      S_SUP_OFF,
      S_HAND_OFF,
      S_ALT_ON,
      S_SET,
      S_C7_A,
      S_C7_B
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [2:0] cnt_ff;
   logic       cond;
   logic       counted;
   logic       emit;
   logic       done;
   sss_op_type op;

   // Decode the current phase: its action, whether it applies, what follows
   always_comb begin
      cond     = 1'b1;
      counted  = 1'b0;
      op       = OP_C7D_OFF;
      state_in = S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cond     = 1'b0;
            state_in = S_IDLE;
         end
         S_C7D_OFF: begin
            cond = sts.on12; op = OP_C7D_OFF; state_in = S_C7A_OFF;
         end
         S_C7A_OFF: begin
            cond = sts.onalt; op = OP_C7A_OFF; state_in = S_ALT_OFF;
         end
         S_ALT_OFF: begin
            cond = !sts.conf_alt; op = OP_ALT_OFF; state_in = S_SUP_ON;
         end
         S_SUP_ON: begin
            cond = sts.conf_sup_off; op = OP_SUP_ON; state_in = S_HAND_ON;
         end
         S_HAND_ON: begin
            cond = sts.on12; counted = 1'b1; op = OP_CONS_ON; state_in = S_SUP_OFF;
         end
         S_SUP_OFF: begin
            cond = sts.on12; op = OP_SUP_OFF; state_in = S_HAND_OFF;
         end
         S_HAND_OFF: begin
            cond = sts.onalt; counted = 1'b1; op = OP_CONS_OFF; state_in = S_ALT_ON;
         end
         S_ALT_ON: begin
            cond = sts.onalt; op = OP_ALT_ON; state_in = S_SET;
         end
         S_SET: begin
            counted = 1'b1; op = OP_CONS_SET; state_in = S_C7_A;
         end
         S_C7_A: begin
            op = OP_C7_FIRST; state_in = S_C7_B;
         end
         S_C7_B: begin
            op = OP_C7_SECOND; state_in = S_IDLE;
         end
         default: begin
            cond     = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   // Emit when the phase applies and the result register can take an item
   assign emit = cond && sts.out_free;
   assign done = !cond || (emit && (!counted || cnt_ff == CONS_LAST));

   assign cmd.emit   = emit;
   assign cmd.op     = op;
   assign cmd.idx    = cnt_ff;
   assign req_tready = (state_ff == S_IDLE);

   // Hold state and the relay counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else if (state_ff == S_IDLE) begin
         cnt_ff <= '0;
         if (req_fire && sts.req_ok) begin
            state_ff <= S_C7D_OFF;
         end
      end else begin
         if (emit && counted && cnt_ff != CONS_LAST) begin
            cnt_ff <= cnt_ff + 3'd1;
         end else if (done) begin
            cnt_ff <= '0;
         end
         if (done) begin
            state_ff <= state_in;
         end
      end
   end

endmodule

// File: rtl/sss_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Supply switchover sequencer datapath
// Request latch, supply levels, settle register and the result register.
// ---------------------------------------------------------------------------
module sss_dp import sss_pkg::*; #(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic        mode,
   input  logic [4:0]  from_index,
   input  logic [4:0]  to_index,
   input  logic        csr_valid,
   input  logic [15:0] csr_data,
   input  sss_cmd_type cmd,
   output sss_sts_type sts,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_relay,
   output logic        rsp_level,
   output logic [15:0] rsp_wait,
   output logic        rsp_last
);

   localparam int IdxLimit = (TABLE_ENTRIES < StoredEntries) ? TABLE_ENTRIES : StoredEntries;
   localparam logic [4:0] PANIC_FROM = 5'(TABLE_ENTRIES - 1);

   logic [15:0]   settle_ff;
   logic          sup_ff;      // relay 7 active: 12V supply off
   logic          alt_ff;      // alternate-supply MOSFETs on
   sss_entry_type conf_ff;
   logic          on12_ff;
   logic          onalt_ff;
   logic          out_valid_ff;
   logic [1:0]    kind_ff;
   logic [2:0]    relay_ff;
   logic          level_ff;
   logic [15:0]   wait_ff;
   logic          last_ff;

   logic [4:0]    from_eff;
   logic [4:0]    to_eff;
   sss_entry_type conf_new;
   logic [6:0]    cons_bits;
   logic [1:0]    kind_in;
   logic [2:0]    relay_in;
   logic          level_in;
   logic          wait_zero;
   logic          last_in;
   logic          sup_in;
   logic          alt_in;

   // Resolve panic and check the indices
   assign from_eff = mode ? PANIC_FROM : from_index;
   assign to_eff   = mode ? 5'd0 : to_index;
   assign conf_new = CONF_TABLE[to_eff[3:0]];

   assign sts.req_ok = ({1'b0, from_eff} < 6'(IdxLimit)) &&
                       ({1'b0, to_eff} < 6'(IdxLimit)) && (from_eff != to_eff);
   assign sts.on12         = on12_ff;
   assign sts.onalt        = onalt_ff;
   assign sts.conf_alt     = conf_ff[BitAlt];
   assign sts.conf_sup_off = conf_ff[BitSupplyOff];
   assign sts.out_free     = !out_valid_ff || rsp_tready;

   assign cons_bits = conf_ff[6:0];

   // Decode the action into result fields and level updates
   always_comb begin
      kind_in   = KIND_RELAY;
      relay_in  = 3'd0;
      level_in  = 1'b0;
      wait_zero = 1'b0;
      last_in   = 1'b0;
      sup_in    = sup_ff;
      alt_in    = alt_ff;
      unique case (cmd.op)
         OP_C7D_OFF:  kind_in = KIND_C7_DIRECT;
         OP_C7A_OFF:  kind_in = KIND_C7_ALT;
         OP_ALT_OFF: begin
            kind_in = KIND_ALT;
            alt_in  = 1'b0;
         end
         OP_SUP_ON: begin
            relay_in = SUPPLY_RELAY;
            level_in = 1'b1;
            sup_in   = 1'b1;
         end
         OP_CONS_ON: begin
            relay_in = cmd.idx;
            level_in = 1'b1;
         end
         OP_SUP_OFF: begin
            relay_in  = SUPPLY_RELAY;
            wait_zero = 1'b1;
            sup_in    = 1'b0;
         end
         OP_CONS_OFF: relay_in = cmd.idx;
         OP_ALT_ON: begin
            kind_in  = KIND_ALT;
            level_in = 1'b1;
            alt_in   = 1'b1;
         end
         OP_CONS_SET: begin
            relay_in = cmd.idx;
            level_in = cons_bits[cmd.idx];
         end
         OP_C7_FIRST: begin
            kind_in = conf_ff[BitC7Direct] ? KIND_C7_ALT : KIND_C7_DIRECT;
         end
         OP_C7_SECOND: begin
            last_in = 1'b1;
            if (conf_ff[BitC7Direct]) begin
               kind_in  = KIND_C7_DIRECT;
               level_in = 1'b1;
            end else begin
               kind_in  = KIND_C7_ALT;
               level_in = conf_ff[BitC7Alt];
            end
         end
         default: kind_in = KIND_RELAY;
      endcase
   end

   // Hold settle time, supply levels and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= SETTLE_RESET;
         sup_ff       <= 1'b0;
         alt_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            settle_ff <= csr_data;
         end
         if (cmd.emit) begin
            sup_ff       <= sup_in;
            alt_ff       <= alt_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Latch the target entry and the hand-over decisions on accept, and the result fields on each emitted action
   always_ff @(posedge clock) begin
      if (req_fire) begin
         conf_ff  <= conf_new;
         on12_ff  <= sup_ff && !conf_new[BitSupplyOff];
         onalt_ff <= !alt_ff && conf_new[BitAlt];
      end
      if (cmd.emit) begin
         kind_ff  <= kind_in;
         relay_ff <= relay_in;
         level_ff <= level_in;
         wait_ff  <= wait_zero ? 16'd0 : settle_ff;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_relay  = relay_ff;
   assign rsp_level  = level_ff;
   assign rsp_wait   = wait_ff;
   assign rsp_last   = last_ff;

endmodule

// File: rtl/supply_switchover_sequencer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Supply switchover sequencer
// Turns a configuration change request into an ordered run of pin actions.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_      in         one transition request (mode, from, to)
//  rsp_      out        one pin action, tlast on the final action of a run
//  csr_      in         settle time in milliseconds
//
//  A valid request is accepted from idle, then the controller walks eleven
//  phases in order: each single-action phase issues its action or is skipped,
//  and each of the three relay phases that applies issues one action per
//  consumer relay.
//  An invalid or same-index request is dropped in its accept cycle.
//  A stalled rsp_ holds the controller in its phase; no request is taken
//  until the run's last action has entered the result register.
//  Reset sets settle time to 500 ms and all relays and MOSFETs inactive.
// ---------------------------------------------------------------------------
`include "supply_switchover_sequencer_top_macros.svh"
module supply_switchover_sequencer_top import sss_pkg::*; #(
   parameter int TABLE_ENTRIES   = TableEntriesDefault,
   parameter int CONSUMER_RELAYS = ConsumerRelaysDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // from_index[4:0], to_index[9:5], zero fill
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // relay_number[2:0], level[3], wait_ms[19:4], zero fill
   output logic [1:0]  rsp_tuser,   // target_kind
   output logic        rsp_tlast,   // last_action
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   sss_cmd_type cmd;
   sss_sts_type sts;
   logic        req_fire;
   logic [2:0]  relay;
   logic        level;
   logic [15:0] wait_ms;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tdata = {4'd0, wait_ms, level, relay};

   sss_ctrl #(
      .CONSUMER_RELAYS(CONSUMER_RELAYS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sss_dp #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .mode      (req_tuser),
      .from_index(req_tdata[4:0]),
      .to_index  (req_tdata[9:5]),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_relay (relay),
      .rsp_level (level),
      .rsp_wait  (wait_ms),
      .rsp_last  (rsp_tlast)
   );

   // Never overwrite a result that is still waiting
   `SSS_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.emit, sts.out_free, "result overwritten")
   // Idle controller issues no actions
   `SSS_ASSERT_IMP(a_idle_quiet, clock, reset, req_tready, !cmd.emit, "action while idle")
   // Final action returns the controller to idle
   `SSS_ASSERT_NXT(a_last_idle, clock, reset, cmd.emit && cmd.op == OP_C7_SECOND,
                   req_tready, "not idle after final action")

endmodule
